FILE: hw/rtl/dsp_pkg.sv
package dsp_pkg;

	localparam int unsigned DIST_W = 16;
	localparam logic [DIST_W-1:0] DIST_INF = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_FOUND       = 2'd0,
		ST_BAD_INDEX   = 2'd1,
		ST_UNREACHABLE = 2'd2
	} status_t;

	typedef enum logic [0:0] {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} opcode_t;

endpackage

FILE: hw/rtl/dijkstra_shortest_path_core.sv
// Channel  | Direction | Handshake          | Beat fields
// ---------+-----------+--------------------+----------------------------------------------
// command  | in        | start && !busy     | opcode node slot neighbor weight edge_valid
//          |           |                    | start_node end_node
// result   | out       | result_valid       | path_node total_cost status last
//
// A load is written at accept and gives no result. A bad index or start == end gives its
// one beat the cycle after accept, busy stays low. Otherwise the core clears every node,
// then runs up to NODES rounds: scan every node (address, compare), then read each slot of
// the pick (address, check) and relax each live slot. The walk back reads and pushes each
// path node; each result beat takes an emit and a done step. Busy is high from accept to
// last beat. The receiver cannot stall; of the edge table, reset clears only present bits.
module dijkstra_shortest_path_core #(
	parameter int unsigned NODES  = 8,
	parameter int unsigned DEGREE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [0:0]  opcode,
	input  logic [5:0]  node,
	input  logic [1:0]  slot,
	input  logic [5:0]  neighbor,
	input  logic [7:0]  weight,
	input  logic [0:0]  edge_valid,
	input  logic [5:0]  start_node,
	input  logic [5:0]  end_node,
	output logic        result_valid,
	output logic [5:0]  path_node,
	output logic [15:0] total_cost,
	output logic [1:0]  status,
	output logic        last
);
	localparam int unsigned NW    = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int unsigned DW    = (DEGREE > 1) ? $clog2(DEGREE) : 1;
	localparam int unsigned SLOTS = NODES * DEGREE;
	localparam int unsigned EW    = $clog2(SLOTS);
	localparam int unsigned CW    = NW + 1;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_CLEAR = 11'b00000000010,
		S_SCAN  = 11'b00000000100,
		S_SCANW = 11'b00000001000,
		S_EREAD = 11'b00000010000,
		S_EDIST = 11'b00000100000,
		S_RELAX = 11'b00001000000,
		S_WALK  = 11'b00010000000,
		S_WALKW = 11'b00100000000,
		S_EMIT  = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;

	// edge table memories
	logic [5:0] etgt_mem [SLOTS];
	logic [7:0] ewt_mem  [SLOTS];
	logic [SLOTS-1:0] epres_q;
	logic [5:0] etgt_rd_q;
	logic [7:0] ewt_rd_q;
	logic       epres_rd_q;

	// scratch memories: distance, predecessor with a no-predecessor flag packed, visited, path stack
	logic [15:0]   dist_mem [NODES];
	logic [NW:0]   pred_mem [NODES];
	logic          vis_mem  [NODES];
	logic [NW-1:0] stk_mem  [NODES];
	logic [15:0]   dist_rd_q;
	logic [NW:0]   pred_rd_q;
	logic          vis_rd_q;
	logic [NW-1:0] stk_rd_q;

	logic [NW-1:0] src_q, dst_q, idx_q, pick_q, cur_q, tgt_q;
	logic [CW-1:0] round_q, depth_q;
	logic [DW-1:0] sl_q;
	logic [15:0]   least_q, cost_q;
	logic          found_q;

	// read address muxes and write controls for the memories
	logic [NW-1:0] d_raddr;
	logic [NW-1:0] s_raddr;
	logic [EW-1:0] e_raddr;
	logic          dist_we;
	logic [NW-1:0] dist_wa;
	logic [15:0]   dist_wd;
	logic          pred_we;
	logic [NW:0]   pred_wd;
	logic          vis_we;
	logic          vis_wd;
	logic          stk_we;
	logic [NW-1:0] stk_wa;
	logic [16:0]   sum;
	logic [15:0]   sum_sat;

	assign e_raddr = EW'(pick_q) * EW'(DEGREE) + EW'(sl_q);
	assign sum     = {1'b0, least_q} + 17'(ewt_rd_q);
	assign sum_sat = sum[16] ? dsp_pkg::DIST_INF : sum[15:0];

	always_comb begin
		d_raddr = idx_q;
		// target is only known from the edge read data while in S_EDIST
		if (state_q == S_EDIST) d_raddr = etgt_rd_q[NW-1:0];
		else if (state_q == S_RELAX) d_raddr = tgt_q;
		else if (state_q == S_WALK || state_q == S_WALKW) d_raddr = cur_q;
		s_raddr = NW'(depth_q - CW'(1));
		dist_we = 1'b0;
		dist_wa = idx_q;
		dist_wd = dsp_pkg::DIST_INF;
		pred_we = 1'b0;
		pred_wd = {1'b1, {NW{1'b0}}};
		vis_we  = 1'b0;
		vis_wd  = 1'b0;
		stk_we  = 1'b0;
		stk_wa  = NW'(depth_q);
		unique case (state_q)
			S_CLEAR: begin
				dist_we = 1'b1;
				pred_we = 1'b1;
				vis_we  = 1'b1;
				if (idx_q == src_q) dist_wd = '0;
			end
			S_RELAX: begin
				dist_wa = tgt_q;
				if (sum_sat < dist_rd_q) begin
					dist_we = 1'b1;
					pred_we = 1'b1;
					dist_wd = sum_sat;
					pred_wd = {1'b0, pick_q};
				end
			end
			S_EREAD: begin
				// first slot cycle of a round marks the pick visited
				if (sl_q == '0) begin
					vis_we  = 1'b1;
					vis_wd  = 1'b1;
					dist_wa = pick_q;
				end
			end
			S_WALKW: begin
				stk_we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dist_we) dist_mem[dist_wa] <= dist_wd;
		if (pred_we) pred_mem[dist_wa] <= pred_wd;
		if (vis_we)  vis_mem[dist_wa]  <= vis_wd;
		if (stk_we)  stk_mem[stk_wa]   <= cur_q;
		dist_rd_q <= dist_mem[d_raddr];
		pred_rd_q <= pred_mem[d_raddr];
		vis_rd_q  <= vis_mem[d_raddr];
		stk_rd_q  <= stk_mem[s_raddr];
	end

	logic load_ok;
	assign load_ok = start && !busy && opcode == dsp_pkg::OP_LOAD
		&& 32'(node) < NODES && 32'(slot) < DEGREE;

	logic [EW-1:0] e_waddr;
	assign e_waddr = EW'(EW'(node[NW-1:0]) * EW'(DEGREE) + EW'(slot));

	always_ff @(posedge clk) begin
		if (load_ok) begin
			etgt_mem[e_waddr] <= neighbor;
			ewt_mem[e_waddr]  <= weight;
		end
		etgt_rd_q  <= etgt_mem[e_raddr];
		ewt_rd_q   <= ewt_mem[e_raddr];
		epres_rd_q <= epres_q[e_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epres_q <= '0;
		end else if (load_ok) begin
			epres_q[e_waddr] <= edge_valid[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
			idx_q        <= '0;
			round_q      <= '0;
			depth_q      <= '0;
			sl_q         <= '0;
			found_q      <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && opcode == dsp_pkg::OP_QUERY) begin
						src_q <= start_node[NW-1:0];
						dst_q <= end_node[NW-1:0];
						if (32'(start_node) >= NODES || 32'(end_node) >= NODES) begin
							result_valid <= 1'b1;
							path_node    <= '0;
							total_cost   <= '0;
							status       <= dsp_pkg::ST_BAD_INDEX;
							last         <= 1'b1;
						end else if (start_node == end_node) begin
							result_valid <= 1'b1;
							path_node    <= start_node;
							total_cost   <= '0;
							status       <= dsp_pkg::ST_FOUND;
							last         <= 1'b1;
						end else begin
							idx_q   <= '0;
							round_q <= '0;
							state_q <= S_CLEAR;
						end
					end
				end
				S_CLEAR: begin
					idx_q <= idx_q + NW'(1);
					if (32'(idx_q) == NODES - 1) begin
						idx_q   <= '0;
						found_q <= 1'b0;
						least_q <= dsp_pkg::DIST_INF;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// read of idx_q issued; data next cycle
					state_q <= S_SCANW;
				end
				S_SCANW: begin
					if (!vis_rd_q && dist_rd_q < least_q) begin
						least_q <= dist_rd_q;
						pick_q  <= idx_q;
						found_q <= 1'b1;
					end
					if (32'(idx_q) == NODES - 1) begin
						idx_q <= '0;
						sl_q  <= '0;
						if (!found_q && !(!vis_rd_q && dist_rd_q < least_q))
							state_q <= S_WALK;
						else
							state_q <= S_EREAD;
						cur_q   <= dst_q;
						depth_q <= '0;
					end else begin
						idx_q   <= idx_q + NW'(1);
						state_q <= S_SCAN;
					end
				end
				S_EREAD: begin
					state_q <= S_EDIST;
				end
				S_EDIST: begin
					tgt_q <= etgt_rd_q[NW-1:0];
					if (!epres_rd_q || 32'(etgt_rd_q) >= NODES) begin
						if (32'(sl_q) == DEGREE - 1) begin
							round_q <= round_q + CW'(1);
							found_q <= 1'b0;
							least_q <= dsp_pkg::DIST_INF;
							state_q <= (32'(round_q) == NODES - 1) ? S_WALK : S_SCAN;
						end else begin
							sl_q    <= sl_q + DW'(1);
							state_q <= S_EREAD;
						end
					end else begin
						state_q <= S_RELAX;
					end
				end
				S_RELAX: begin
					if (32'(sl_q) == DEGREE - 1) begin
						round_q <= round_q + CW'(1);
						found_q <= 1'b0;
						least_q <= dsp_pkg::DIST_INF;
						state_q <= (32'(round_q) == NODES - 1) ? S_WALK : S_SCAN;
					end else begin
						sl_q    <= sl_q + DW'(1);
						state_q <= S_EREAD;
					end
				end
				S_WALK: begin
					state_q <= S_WALKW;
				end
				S_WALKW: begin
					// dist/pred/vis of cur_q now valid; cur_q pushed this cycle
					if (depth_q == '0) begin
						cost_q <= dist_rd_q;
					end
					depth_q <= depth_q + CW'(1);
					if (depth_q == '0 && !vis_rd_q) begin
						state_q      <= S_DONE;
						result_valid <= 1'b1;
						path_node    <= '0;
						total_cost   <= '0;
						status       <= dsp_pkg::ST_UNREACHABLE;
						last         <= 1'b1;
					end else if (cur_q == src_q) begin
						state_q <= S_EMIT;
					end else if (pred_rd_q[NW] || 32'(depth_q) == NODES - 1) begin
						state_q      <= S_DONE;
						result_valid <= 1'b1;
						path_node    <= '0;
						total_cost   <= '0;
						status       <= dsp_pkg::ST_UNREACHABLE;
						last         <= 1'b1;
					end else begin
						cur_q   <= pred_rd_q[NW-1:0];
						state_q <= S_WALK;
					end
				end
				S_EMIT: begin
					// stack read of depth_q-1 issued; data arrives next cycle
					state_q <= S_DONE;
					found_q <= 1'b1;
				end
				S_DONE: begin
					if (found_q) begin
						result_valid <= 1'b1;
						path_node    <= 6'(stk_rd_q);
						total_cost   <= cost_q;
						status       <= dsp_pkg::ST_FOUND;
						last         <= (depth_q == CW'(1));
						depth_q      <= depth_q - CW'(1);
						if (depth_q == CW'(1)) begin
							found_q <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_EMIT;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid || $past(state_q) == S_IDLE)
		else $error("result after last");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != dsp_pkg::ST_FOUND |-> last)
		else $error("status beat without last");
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> depth_q != '0)
		else $error("emit with empty stack");
endmodule

FILE: tb/sv/dsp_path_checker.sv
module dsp_path_checker #(
	parameter int unsigned NODES  = 8,
	parameter int unsigned DEGREE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [0:0]  opcode,
	input  logic [5:0]  node,
	input  logic [1:0]  slot,
	input  logic [5:0]  neighbor,
	input  logic [7:0]  weight,
	input  logic [0:0]  edge_valid,
	input  logic [5:0]  start_node,
	input  logic [5:0]  end_node,
	input  logic        result_valid,
	input  logic [5:0]  path_node,
	input  logic [15:0] total_cost,
	input  logic [1:0]  status,
	input  logic        last,
	output int          errors,
	output int          pending
);
	typedef struct packed {
		logic [5:0]  pnode;
		logic [15:0] cost;
		logic [1:0]  st;
		logic        lst;
	} hop_t;

	localparam int unsigned SLOTS = NODES * DEGREE;

	logic [5:0] tgt_m [SLOTS];
	logic [7:0] wgt_m [SLOTS];
	logic       prs_m [SLOTS];
	hop_t       hops_q [$];

	task automatic report(input string what, input int unsigned got, input int unsigned want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic hop_t mk(logic [5:0] n, logic [15:0] c, dsp_pkg::status_t s, logic l);
		hop_t h;
		h.pnode = n; h.cost = c; h.st = s; h.lst = l;
		return h;
	endfunction

	function automatic void add_hop(hop_t h);
		hops_q = {hops_q, h};
	endfunction

	task automatic route_predict(input int unsigned src, input int unsigned dst);
		logic [15:0] dist_v [NODES];
		int          pred [NODES];
		bit          done [NODES];
		int          stack [$];
		int          pick, cur, t;
		logic [15:0] least;
		int unsigned sum;
		if (src >= NODES || dst >= NODES) begin
			add_hop(mk(6'd0, 16'd0, dsp_pkg::ST_BAD_INDEX, 1'b1));
			return;
		end
		if (src == dst) begin
			add_hop(mk(6'(src), 16'd0, dsp_pkg::ST_FOUND, 1'b1));
			return;
		end
		for (int i = 0; i < NODES; i++) begin
			dist_v[i] = dsp_pkg::DIST_INF; pred[i] = -1; done[i] = 0;
		end
		dist_v[src] = 0;
		for (int r = 0; r < NODES; r++) begin
			pick = -1; least = dsp_pkg::DIST_INF;
			for (int i = 0; i < NODES; i++)
				if (!done[i] && dist_v[i] < least) begin
					least = dist_v[i]; pick = i;
				end
			if (pick < 0) break;
			done[pick] = 1;
			for (int s = 0; s < DEGREE; s++) begin
				t = int'(tgt_m[pick*DEGREE+s]);
				if (!prs_m[pick*DEGREE+s] || t >= NODES) continue;
				sum = 32'(least) + 32'(wgt_m[pick*DEGREE+s]);
				if (sum > dsp_pkg::DIST_INF) sum = dsp_pkg::DIST_INF;
				if (sum < dist_v[t]) begin
					dist_v[t] = 16'(sum); pred[t] = pick;
				end
			end
		end
		if (!done[dst]) begin
			add_hop(mk(6'd0, 16'd0, dsp_pkg::ST_UNREACHABLE, 1'b1));
			return;
		end
		cur = dst;
		while (stack.size() < NODES) begin
			stack.push_front(cur);
			if (cur == src) break;
			if (pred[cur] < 0) begin
				add_hop(mk(6'd0, 16'd0, dsp_pkg::ST_UNREACHABLE, 1'b1));
				return;
			end
			cur = pred[cur];
		end
		if (stack[0] != src) begin
			add_hop(mk(6'd0, 16'd0, dsp_pkg::ST_UNREACHABLE, 1'b1));
			return;
		end
		foreach (stack[i])
			add_hop(mk(6'(stack[i]), dist_v[dst], dsp_pkg::ST_FOUND, i == stack.size()-1));
	endtask

	initial begin
		errors = 0;
		pending = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tgt_m[i] = 0; wgt_m[i] = 0; prs_m[i] = 0;
		end
	end

	always @(posedge clk) begin
		hop_t h;
		if (arst_n) begin
			// results first: a query's results never share its accept edge
			if (result_valid) begin
				if (hops_q.size() == 0) begin
					report("unexpected beat node", 32'(path_node), 0);
				end else begin
					h = hops_q.pop_front();
					if (path_node !== h.pnode)
						report("path_node", 32'(path_node), 32'(h.pnode));
					if (total_cost !== h.cost)
						report("total_cost", 32'(total_cost), 32'(h.cost));
					if (status !== h.st) report("status", 32'(status), 32'(h.st));
					if (last !== h.lst) report("last", 32'(last), 32'(h.lst));
				end
			end
			if (start && !busy) begin
				if (opcode == dsp_pkg::OP_LOAD) begin
					if (node < NODES && slot < DEGREE) begin
						tgt_m[node*DEGREE+slot] = neighbor;
						wgt_m[node*DEGREE+slot] = weight;
						prs_m[node*DEGREE+slot] = edge_valid;
					end
				end else begin
					route_predict(32'(start_node), 32'(end_node));
				end
			end
		end
		pending = hops_q.size();
	end
endmodule

FILE: tb/sv/tb_dijkstra_shortest_path_core.sv
module tb_dijkstra_shortest_path_core;
	localparam int unsigned NODES  = 8;
	localparam int unsigned DEGREE = 4;
	// idle cycles allowed with no beat moving either way
	localparam int WATCHDOG = 5000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic        busy;
	logic [0:0]  opcode = dsp_pkg::OP_LOAD;
	logic [5:0]  node = 0;
	logic [1:0]  slot = 0;
	logic [5:0]  neighbor = 0;
	logic [7:0]  weight = 0;
	logic [0:0]  edge_valid = 0;
	logic [5:0]  start_node = 0;
	logic [5:0]  end_node = 0;
	logic        result_valid;
	logic [5:0]  path_node;
	logic [15:0] total_cost;
	logic [1:0]  status;
	logic        last;
	int          errors, pending;
	int          idle_cycles = 0;

	always #5 clk = ~clk;

	dijkstra_shortest_path_core #(.NODES(NODES), .DEGREE(DEGREE)) DUT (.*);

	dsp_path_checker #(.NODES(NODES), .DEGREE(DEGREE)) u_checker (.*);

	// watchdog: any accepted command or result beat resets the count
	always @(posedge clk) begin
		if ((start && !busy) || result_valid)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// present one command beat from the falling edge and hold until accepted
	task automatic send_cmd(input logic op, input logic [5:0] n, input logic [1:0] s,
			input logic [5:0] nb, input logic [7:0] w, input logic v,
			input logic [5:0] sn, input logic [5:0] en);
		@(negedge clk);
		start <= 1; opcode <= op; node <= n; slot <= s; neighbor <= nb;
		weight <= w; edge_valid <= v; start_node <= sn; end_node <= en;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic load_edge(input logic [5:0] n, input logic [1:0] s,
			input logic [5:0] nb, input logic [7:0] w, input logic v);
		send_cmd(dsp_pkg::OP_LOAD, n, s, nb, w, v, 6'($urandom), 6'($urandom));
	endtask

	task automatic query(input logic [5:0] sn, input logic [5:0] en);
		send_cmd(dsp_pkg::OP_QUERY, 6'($urandom), 2'($urandom), 6'($urandom),
			8'($urandom), 1'($urandom), sn, en);
	endtask

	task automatic gap(input int n);
		@(negedge clk);
		start <= 0;
		repeat (n) @(negedge clk);
	endtask

	// mostly in-range nodes, sometimes anything in the field
	function automatic logic [5:0] pick_node();
		if ($urandom_range(0, 9) == 0) return 6'($urandom);
		return 6'($urandom_range(0, NODES - 1));
	endfunction

	initial begin
		int burst;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: empty graph, bad indexes, start equals end
		query(0, 1);
		query(63, 0);
		query(0, 63);
		query(8, 8);
		query(5, 5);
		// chain 0->1->2->3 plus a cheaper detour via 4, and a costly 0->5->3 branch
		load_edge(0, 0, 1, 10, 1);
		load_edge(1, 0, 2, 10, 1);
		load_edge(2, 0, 3, 10, 1);
		load_edge(0, 1, 4, 5, 1);
		load_edge(4, 0, 2, 5, 1);
		load_edge(0, 2, 5, 255, 1);
		load_edge(5, 3, 3, 0, 1);
		load_edge(0, 3, 63, 1, 1);   // edge to a missing node
		load_edge(63, 0, 1, 1, 1);   // load to a bad place
		query(0, 3);
		query(0, 5);
		query(3, 0);                 // unreachable
		load_edge(0, 2, 5, 0, 0);    // slot cleared
		query(0, 5);
		// full-weight chain visiting every node
		for (int i = 0; i < NODES - 1; i++) load_edge(6'(i), 3, 6'(i + 1), 8'hFF, 1);
		query(0, 6'(NODES - 1));
		query(7, 0);
		gap(3);

		// random bursts: graph edits interleaved with queries
		for (int k = 0; k < 82; k += burst) begin
			burst = $urandom_range(1, 8);
			for (int j = 0; j < burst; j++) begin
				if ($urandom_range(0, 2) == 0)
					query(pick_node(), pick_node());
				else
					load_edge(pick_node(), 2'($urandom), pick_node(), 8'($urandom),
						$urandom_range(0, 3) != 0);
			end
			if ($urandom_range(0, 2) != 0) gap($urandom_range(0, 20));
		end
		gap(0);

		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
